/* hw/rtl/csp_pkg.sv */
`default_nettype none
package csp_pkg;

  localparam int SPRITE_DIM = 64;
  localparam int POS_W      = $clog2(SPRITE_DIM);
  localparam int DIM_W      = 7;
  localparam int CMP_W      = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;
  localparam int ADDR_W     = 10;
  localparam int ADDR_FW    = 2 * POS_W;
  localparam int ROW_BYTES  = SPRITE_DIM / 4;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(64);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(64);
  localparam logic [7:0]       PACK_PRESET  = 8'hAA;
  localparam logic [9:0]       LIGHT_SUM    = 10'd384;
  localparam logic [7:0]       ALPHA_MIN    = 8'd128;

  typedef enum logic [1:0] {
    CODE_DARK  = 2'b00,
    CODE_LIGHT = 2'b01,
    CODE_CLEAR = 2'b10
  } code_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_ORDER  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             byte_order;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
  } pos_t;

endpackage
`default_nettype wire

/* hw/rtl/csp_classify.sv */
`default_nettype none
module csp_classify
  import csp_pkg::*;
(
  input  logic [7:0] byte_zero,
  input  logic [7:0] byte_one,
  input  logic [7:0] byte_two,
  input  logic [7:0] alpha,
  input  logic       byte_order,
  output code_t      code
);

  logic [7:0] red;
  logic [7:0] blue;
  logic [9:0] colour_sum;

  always_comb begin
    if (byte_order) begin
      red  = byte_zero;
      blue = byte_two;
    end else begin
      blue = byte_zero;
      red  = byte_two;
    end
  end

  assign colour_sum = 10'(red) + 10'(byte_one) + 10'(blue);

  always_comb begin
    if (alpha < ALPHA_MIN) begin
      code = CODE_CLEAR;
    end else if (colour_sum >= LIGHT_SUM) begin
      code = CODE_LIGHT;
    end else begin
      code = CODE_DARK;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/csp_pack.sv */
`default_nettype none
module csp_pack
  import csp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  code_t             code,
  input  logic [DIM_W-1:0]  image_width,
  input  logic [DIM_W-1:0]  image_height,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        sprite_byte,
  output logic [ADDR_W-1:0] byte_address,
  output logic              image_done,
  output pos_t              pos
);

  logic [POS_W-1:0]   column;
  logic [POS_W-1:0]   row;
  logic [7:0]         pack;
  logic [7:0]         pack_next;
  logic [CMP_W-1:0]   width_lim;
  logic [CMP_W-1:0]   height_lim;
  logic               row_end;
  logic               img_end;
  logic               emit;
  logic [ADDR_FW-1:0] addr_full;

  function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [CMP_W-1:0] vx;
    vx = CMP_W'(v);
    if (vx == '0) begin
      return CMP_W'(1);
    end else if (vx > CMP_W'(SPRITE_DIM)) begin
      return CMP_W'(SPRITE_DIM);
    end else begin
      return vx;
    end
  endfunction

  assign width_lim  = clamp_dim(image_width);
  assign height_lim = clamp_dim(image_height);
  assign row_end    = (CMP_W'(column) + CMP_W'(1)) >= width_lim;
  assign img_end    = row_end && ((CMP_W'(row) + CMP_W'(1)) >= height_lim);
  assign emit       = (column[1:0] == 2'b11) || row_end;
  assign addr_full  = ADDR_FW'(row) * ADDR_FW'(ROW_BYTES) + ADDR_FW'(column >> 2);

  always_comb begin
    pack_next = pack;
    pack_next[{column[1:0], 1'b0} +: 2] = code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      row       <= '0;
      pack      <= PACK_PRESET;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        if (row_end) begin
          column <= '0;
          row    <= img_end ? '0 : row + POS_W'(1);
        end else begin
          column <= column + POS_W'(1);
        end
        pack <= emit ? PACK_PRESET : pack_next;
      end
      if (fire && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      sprite_byte  <= pack_next;
      byte_address <= ADDR_W'(addr_full);
      image_done   <= img_end;
    end
  end

  assign pos.column = column;
  assign pos.row    = row;

endmodule
`default_nettype wire

/* hw/rtl/cursor_sprite_packer_top.sv */
`default_nettype none
// A pixel in the pixel register is processed once the output register is free, and that
// edge also loads its byte, if the pixel completes one, into the master-side register.
// Throughput: one pixel per cycle unless output stalls, via the single pass from the pixel
// register to the output register; a byte leaves for every four pixels and at each row end.
// Reset clears the position to the first pixel, the packing byte to all transparent, both
// sides to empty and the registers to width 64, height 64 and B,G,R,A order.
module cursor_sprite_packer_top
  import csp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // byte_zero, byte_one, byte_two, alpha
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // sprite_byte, byte_address, zero padding
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  cfg_t              cfg;
  logic              pix_valid;
  logic [31:0]       pix;
  logic              out_free;
  logic              fire;
  code_t             code;
  logic [7:0]        sprite_byte;
  logic [ADDR_W-1:0] byte_address;
  pos_t              pos;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign fire      = pix_valid && out_free;
  assign s_tready  = !pix_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= WIDTH_RESET;
      cfg.image_height <= HEIGHT_RESET;
      cfg.byte_order   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  cfg.image_width  <= cfg_data;
        CFG_HEIGHT: cfg.image_height <= cfg_data;
        CFG_ORDER:  cfg.byte_order   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      pix_valid <= 1'b1;
    end else if (fire) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pix <= s_tdata;
    end
  end

  csp_classify u_classify (
    .byte_zero  (pix[7:0]),
    .byte_one   (pix[15:8]),
    .byte_two   (pix[23:16]),
    .alpha      (pix[31:24]),
    .byte_order (cfg.byte_order),
    .code       (code)
  );

  csp_pack u_pack (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .code         (code),
    .image_width  (cfg.image_width),
    .image_height (cfg.image_height),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .sprite_byte  (sprite_byte),
    .byte_address (byte_address),
    .image_done   (m_tlast),
    .pos          (pos)
  );

  assign m_tdata = {6'b0, byte_address, sprite_byte};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input side stalled while the output register is empty");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    pix_valid && m_tvalid && !m_tready |-> !s_tready && !fire)
    else $error("pixel taken while both stages are full");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && $past(fire) |-> pos.column == '0 && pos.row == '0)
    else $error("position not back at the origin after the last byte of an image");

endmodule
`default_nettype wire

/* verif/cursor_sprite_packer_top_tb.sv */
`default_nettype none
module cursor_sprite_packer_top_tb;
  import csp_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 12;

  typedef struct packed {
    logic [7:0] sprite_byte;
    logic [9:0] byte_address;
    logic       image_done;
  } sprite_write_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  cursor_sprite_packer_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [31:0]   pixel_queue[$];
  sprite_write_t pending_writes[$];

  logic [DIM_W-1:0] reg_width  = WIDTH_RESET;
  logic [DIM_W-1:0] reg_height = HEIGHT_RESET;
  logic             reg_order  = 1'b0;
  int               pos_column = 0;
  int               pos_row    = 0;
  logic [7:0]       pack_byte  = PACK_PRESET;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors        = 0;
  int pixels_sent   = 0;
  int bytes_checked = 0;
  int images_done   = 0;
  int reg_writes    = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout with %0d pixels queued, %0d bytes outstanding",
             pixel_queue.size(), pending_writes.size());
    $display("status: fail");
    $finish;
  end

  function automatic int clamp_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > SPRITE_DIM) return SPRITE_DIM;
    return int'(v);
  endfunction

  task automatic pack_pixel(input logic [31:0] px);
    logic [7:0]    red, green, blue, alpha;
    code_t         code;
    int            w, h, shift, sum;
    bit            row_end, img_end;
    sprite_write_t wr;
    green = px[15:8];
    alpha = px[31:24];
    if (reg_order) begin
      red  = px[7:0];
      blue = px[23:16];
    end else begin
      blue = px[7:0];
      red  = px[23:16];
    end
    w = clamp_dim(reg_width);
    h = clamp_dim(reg_height);
    sum = int'(red) + int'(green) + int'(blue);
    if (alpha < ALPHA_MIN) code = CODE_CLEAR;
    else if (sum >= int'(LIGHT_SUM)) code = CODE_LIGHT;
    else code = CODE_DARK;
    shift = (pos_column % 4) * 2;
    pack_byte[3'(shift) +: 2] = code;
    row_end = (pos_column + 1) >= w;
    img_end = row_end && ((pos_row + 1) >= h);
    if ((pos_column % 4) == 3 || row_end) begin
      wr.sprite_byte  = pack_byte;
      wr.byte_address = 10'(pos_row * ROW_BYTES + pos_column / 4);
      wr.image_done   = img_end;
      pending_writes.push_back(wr);
      pack_byte = PACK_PRESET;
      if (img_end) images_done++;
      if (row_end) begin
        pos_column = 0;
        pos_row = img_end ? 0 : pos_row + 1;
      end else begin
        pos_column++;
      end
    end else begin
      pos_column++;
    end
  endtask

  task automatic note_error(input string what, input int unsigned want, input int unsigned got);
    errors++;
    if (errors <= 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pack_pixel(s_tdata);
        void'(pixel_queue.pop_front());
        pixels_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pixel_queue[0];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    sprite_write_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_writes.size() == 0) begin
        note_error("unexpected sprite byte", 0, 32'(m_tdata[17:0]));
      end else begin
        want = pending_writes.pop_front();
        if (m_tdata[7:0] !== want.sprite_byte)
          note_error("sprite_byte", 32'(want.sprite_byte), 32'(m_tdata[7:0]));
        if (m_tdata[17:8] !== want.byte_address)
          note_error("byte_address", 32'(want.byte_address), 32'(m_tdata[17:8]));
        if (m_tlast !== want.image_done)
          note_error("image_done", 32'(want.image_done), 32'(m_tlast));
        bytes_checked++;
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WIDTH:  reg_width  = val;
      CFG_HEIGHT: reg_height = val;
      CFG_ORDER:  reg_order  = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic settle();
    while (pixel_queue.size() != 0 || pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] near_threshold();
    return 8'($urandom_range(124, 131));
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    case ($urandom_range(3))
      0: px = $urandom;
      1: px = {near_threshold(), 8'($urandom), 8'($urandom), 8'($urandom)};
      2: px = {8'($urandom_range(128, 255)), near_threshold(), near_threshold(),
               near_threshold()};
      default: begin
        px = $urandom;
        for (int i = 0; i < 4; i++)
          if ($urandom_range(1)) px[5'(8*i) +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
    endcase
    return px;
  endfunction

  function automatic logic [6:0] random_dim();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'($urandom_range(65, 127));
      4, 5, 6: return 7'($urandom_range(1, 8));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    int count;
    send_idle_pct = 9;
    recv_idle_pct = 85;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: a 64-wide row, so the position is left mid-row.
    pixel_queue.push_back({8'h00, 8'h00, 8'h00, 8'h00});
    pixel_queue.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    pixel_queue.push_back({8'h7F, 8'hFF, 8'hFF, 8'hFF});
    pixel_queue.push_back({8'h80, 8'h00, 8'h00, 8'h00});
    pixel_queue.push_back({8'h80, 8'h80, 8'h80, 8'h80});
    pixel_queue.push_back({8'hFF, 8'h7F, 8'h80, 8'h80});
    pixel_queue.push_back({8'hFF, 8'h00, 8'hFF, 8'hFF});
    pixel_queue.push_back({8'hFF, 8'hFF, 8'h00, 8'h81});
    settle();

    // Zero width while past column zero: the next item closes its row.
    write_reg(CFG_WIDTH, 7'd0);
    pixel_queue.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    pixel_queue.push_back({8'hC0, 8'h40, 8'h40, 8'h40});
    settle();
    write_reg(CFG_HEIGHT, 7'd0);
    pixel_queue.push_back({8'h80, 8'hFF, 8'hFF, 8'hFF});
    pixel_queue.push_back({8'h10, 8'h00, 8'h00, 8'h00});
    settle();

    write_reg(CFG_WIDTH, 7'd127);
    write_reg(CFG_HEIGHT, 7'd127);
    write_reg(CFG_ORDER, 7'h7F);
    write_reg(CFG_SPARE, 7'h55);
    for (int i = 0; i < 5; i++) pixel_queue.push_back(random_pixel());
    settle();

    write_reg(CFG_WIDTH, 7'd5);
    write_reg(CFG_HEIGHT, 7'd2);
    write_reg(CFG_ORDER, 7'h00);
    for (int i = 0; i < 10; i++) pixel_queue.push_back(random_pixel());
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p * 3 / RANDOM_PHASES)
        0: begin send_idle_pct = 9;  recv_idle_pct = 85; end
        1: begin send_idle_pct = 85; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if ($urandom_range(2) != 0) write_reg(CFG_WIDTH, random_dim());
      if ($urandom_range(2) != 0) write_reg(CFG_HEIGHT, random_dim());
      if ($urandom_range(2) != 0) write_reg(CFG_ORDER, 7'($urandom));
      if ($urandom_range(4) == 0) write_reg(CFG_SPARE, 7'($urandom));
      count = $urandom_range(100, 150);
      for (int i = 0; i < count; i++) pixel_queue.push_back(random_pixel());
      settle();
    end

    $display("covered %0d pixels, %0d sprite bytes checked, %0d images completed",
             pixels_sent, bytes_checked, images_done);
    $display("%0d register writes, %0d mismatches", reg_writes, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
